// File: src/swl_pkg.sv
`default_nettype none

package swl_pkg;

    // outbox capacity and the width of its fill count
    localparam int OUTBOX_DEPTH = 16;
    localparam int QUEUE_W      = $clog2(OUTBOX_DEPTH + 1);

    // idle epoch counter saturates here
    localparam logic [7:0] EPOCH_CNT_MAX = 8'hFF;
    localparam logic [7:0] EPOCH_LIMIT_RESET = 8'd5;

    // maximum results caused by one event
    localparam int MAX_RESULTS = 3;

    // event codes
    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_RECV    = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_CONNECT = 3'd3;
    localparam logic [2:0] OP_CLOSE   = 3'd4;

    // action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_DATA    = 3'd1;
    localparam logic [2:0] ACT_ACK     = 3'd2;
    localparam logic [2:0] ACT_DELIVER = 3'd3;
    localparam logic [2:0] ACT_CONNECT = 3'd4;
    localparam logic [2:0] ACT_REJECT  = 3'd5;
    localparam logic [2:0] ACT_TIMEOUT = 3'd6;
    localparam logic [2:0] ACT_CLOSED  = 3'd7;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] msg_conn_id;
        logic [31:0] msg_seq;
        logic [15:0] msg_length;
        logic        connect_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq_out;
        logic [31:0] conn_out;
        logic        was_open;
        logic        last;
    } t_out_item;

    // all results of one event, in order, with their count
    typedef struct packed {
        logic [1:0]                   cnt;
        t_out_item [MAX_RESULTS-1:0]  res;
    } t_bundle;

endpackage

`default_nettype wire

// File: src/swl_if.sv
`default_nettype none

// event channel into the link client
interface swl_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] msg_conn_id;
    logic [31:0] msg_seq;
    logic [15:0] msg_length;
    logic        connect_ok;

    modport source (
        output valid, operation, msg_conn_id, msg_seq, msg_length, connect_ok,
        input  ready
    );
    modport sink (
        input  valid, operation, msg_conn_id, msg_seq, msg_length, connect_ok,
        output ready
    );
endinterface

// action channel out of the link client
interface swl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] seq_out;
    logic [31:0] conn_out;
    logic        was_open;
    logic        last;

    modport source (
        output valid, action, seq_out, conn_out, was_open, last,
        input  ready
    );
    modport sink (
        input  valid, action, seq_out, conn_out, was_open, last,
        output ready
    );
endinterface

// register write channel
interface swl_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

// File: src/stop_and_wait_link_client.sv
`default_nettype none

// Client side of a stop-and-wait link.
// i_in carries events (write, received message, epoch tick, connect reply,
// close); o_out carries the resulting actions, one transaction each, with
// last set on the final action of an event. i_cfg writes epoch_limit; a
// zero write is dropped. i_cfg is always ready.
// The first action of an event is valid the cycle after the event is
// accepted. An event yields one to three actions, and the output register
// sends one per cycle while o_out is ready, so one event per cycle passes
// when each gives a single action and o_out is ready.
// The next event is accepted in the same cycle that the last action of the
// previous one is taken, or whenever the output register is empty.
// When the receiver stalls, the pending action holds and i_in stays stalled
// until the last action of the buffered event is taken.
// Reset (synchronous, active low) puts the link in connect sent with all
// counters at zero, epoch_limit at 5 and the output register empty.
module stop_and_wait_link_client
    import swl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    swl_in_if.sink      i_in,
    swl_out_if.source   o_out,
    swl_cfg_if.sink     i_cfg
);

    t_in_item   item;
    t_bundle    bundle;
    logic       in_accept;
    logic       out_pop;
    logic       out_done;

    logic [1:0]                  r_cnt;
    logic [1:0]                  r_idx;
    t_out_item [MAX_RESULTS-1:0] r_res;
    t_out_item                   cur;

    assign item.operation   = i_in.operation;
    assign item.msg_conn_id = i_in.msg_conn_id;
    assign item.msg_seq     = i_in.msg_seq;
    assign item.msg_length  = i_in.msg_length;
    assign item.connect_ok  = i_in.connect_ok;

    assign i_cfg.ready = 1'b1;

    swl_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (item),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_bundle   (bundle)
    );

    // output register handshake
    assign cur         = r_res[r_idx];
    assign o_out.valid = r_cnt != 2'd0;
    assign out_pop     = o_out.valid && o_out.ready;
    assign out_done    = out_pop && cur.last;
    assign i_in.ready  = (r_cnt == 2'd0) || out_done;
    assign in_accept   = i_in.valid && i_in.ready;

    assign o_out.action   = cur.action;
    assign o_out.seq_out  = cur.seq_out;
    assign o_out.conn_out = cur.conn_out;
    assign o_out.was_open = cur.was_open;
    assign o_out.last     = cur.last;

    // load a new event's actions, advance on each taken action
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (in_accept) begin
            r_cnt <= bundle.cnt;
            r_idx <= '0;
        end else if (out_done) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (out_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= bundle.res;
        end
    end

    // an event is taken only when the previous one is fully drained
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (r_cnt == 2'd0) || (out_pop && cur.last))
        else $error("event accepted over pending actions");

    // the read pointer stays inside the buffered actions
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_idx < r_cnt)
        else $error("action index past count");

    // every accepted event shows an action next cycle
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out.valid && r_idx == 2'd0)
        else $error("no action after accepted event");

    // the final buffered action is the one marked last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (r_idx == r_cnt - 2'd1) |-> o_out.last)
        else $error("final action not marked last");

endmodule

`default_nettype wire

// File: src/swl_core.sv
`default_nettype none

module swl_core
    import swl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire logic     i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    output t_bundle       o_bundle
);

    typedef enum logic [1:0] {
        LS_CONNECT_SENT = 2'd0,
        LS_CONNECTED    = 2'd1,
        LS_DISCONNECTED = 2'd2
    } t_link;

    t_link              r_link, n_link;
    logic [31:0]        r_conn, n_conn;
    logic [31:0]        r_sent, n_sent;
    logic [31:0]        r_recv, n_recv;
    logic [31:0]        r_acked, n_acked;
    logic [31:0]        r_trans, n_trans;
    logic [QUEUE_W-1:0] r_queued, n_queued;
    logic [7:0]         r_idle, n_idle;
    logic [7:0]         r_limit;

    function automatic t_out_item mk(input logic [2:0] act, input logic [31:0] seq,
                                     input logic [31:0] conn, input logic open);
        t_out_item r;
        r.action   = act;
        r.seq_out  = seq;
        r.conn_out = conn;
        r.was_open = open;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic t_bundle emit(input t_bundle b, input t_out_item r);
        t_bundle o;
        o = b;
        o.res[b.cnt] = r;
        o.cnt = b.cnt + 2'd1;
        return o;
    endfunction

    logic [31:0] front_now;
    logic [31:0] front_next;
    logic [31:0] ack_next_p1;
    logic        do_check;
    t_bundle     bnd;

    assign front_now = r_sent - 32'(r_queued) + 32'd1;

    // next state and result list for the event on the input
    always_comb begin
        n_link   = r_link;
        n_conn   = r_conn;
        n_sent   = r_sent;
        n_recv   = r_recv;
        n_acked  = r_acked;
        n_trans  = r_trans;
        n_queued = r_queued;
        n_idle   = r_idle;
        do_check = 1'b0;
        bnd      = '0;

        case (i_item.operation)
            OP_WRITE: begin
                if (i_item.msg_length == 16'd0 || r_queued >= QUEUE_W'(OUTBOX_DEPTH)) begin
                    bnd = emit(bnd, mk(ACT_REJECT, 32'd0, 32'd0, 1'b0));
                end else begin
                    n_sent   = r_sent + 32'd1;
                    n_queued = r_queued + QUEUE_W'(1);
                    do_check = 1'b1;
                end
            end
            OP_RECV: begin
                if (r_link != LS_DISCONNECTED && i_item.msg_conn_id == r_conn) begin
                    n_idle   = 8'd0;
                    do_check = 1'b1;
                    if (i_item.msg_length == 16'd0) begin
                        if (i_item.msg_seq == r_acked + 32'd1) begin
                            n_acked = i_item.msg_seq;
                        end
                        if (r_queued != '0 && i_item.msg_seq == front_now) begin
                            n_queued = r_queued - QUEUE_W'(1);
                        end
                    end else if (i_item.msg_seq == r_recv + 32'd1) begin
                        n_recv = i_item.msg_seq;
                        bnd = emit(bnd, mk(ACT_DELIVER, i_item.msg_seq, r_conn, 1'b0));
                        bnd = emit(bnd, mk(ACT_ACK, i_item.msg_seq, r_conn, 1'b0));
                    end
                end
            end
            OP_TICK: begin
                if (r_link != LS_DISCONNECTED) begin
                    if (r_link == LS_CONNECT_SENT) begin
                        bnd = emit(bnd, mk(ACT_CONNECT, 32'd0, 32'd0, 1'b0));
                    end else begin
                        bnd = emit(bnd, mk(ACT_ACK, r_recv, r_conn, 1'b0));
                        if (r_queued != '0) begin
                            bnd = emit(bnd, mk(ACT_DATA, front_now, r_conn, 1'b0));
                        end
                    end
                    if (r_idle != EPOCH_CNT_MAX) begin
                        n_idle = r_idle + 8'd1;
                    end
                    if (n_idle >= r_limit) begin
                        n_link = LS_DISCONNECTED;
                        bnd = emit(bnd, mk(ACT_TIMEOUT, 32'd0, 32'd0, 1'b0));
                    end
                end
            end
            OP_CONNECT: begin
                if (r_link == LS_CONNECT_SENT && i_item.connect_ok) begin
                    n_conn = i_item.msg_conn_id;
                    n_link = LS_CONNECTED;
                end
                do_check = 1'b1;
            end
            OP_CLOSE: begin
                n_link = LS_DISCONNECTED;
                bnd = emit(bnd, mk(ACT_CLOSED, 32'd0, 32'd0, r_link != LS_DISCONNECTED));
            end
            default: begin
            end
        endcase

        // send the outbox front once the previous message is acknowledged
        ack_next_p1 = n_acked + 32'd1;
        front_next  = n_sent - 32'(n_queued) + 32'd1;
        if (do_check && n_link == LS_CONNECTED && ack_next_p1 > n_trans && n_queued != '0) begin
            bnd     = emit(bnd, mk(ACT_DATA, front_next, n_conn, 1'b0));
            n_trans = front_next;
        end

        // an event with no effect still reports once
        if (bnd.cnt == 2'd0) begin
            bnd = emit(bnd, mk(ACT_NONE, 32'd0, 32'd0, 1'b0));
        end
        bnd.res[bnd.cnt - 2'd1].last = 1'b1;
    end

    assign o_bundle = bnd;

    // hold link state; advance it on each accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link   <= LS_CONNECT_SENT;
            r_conn   <= '0;
            r_sent   <= '0;
            r_recv   <= '0;
            r_acked  <= '0;
            r_trans  <= '0;
            r_queued <= '0;
            r_idle   <= '0;
            r_limit  <= EPOCH_LIMIT_RESET;
        end else begin
            if (i_accept) begin
                r_link   <= n_link;
                r_conn   <= n_conn;
                r_sent   <= n_sent;
                r_recv   <= n_recv;
                r_acked  <= n_acked;
                r_trans  <= n_trans;
                r_queued <= n_queued;
                r_idle   <= n_idle;
            end
            // drop a zero limit, keep the old one
            if (i_cfg_we && i_cfg_data != 8'd0) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // a lost or closed link never reopens
    a_disc_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link == LS_DISCONNECTED |=> r_link == LS_DISCONNECTED)
        else $error("link left the disconnected state");

    // outbox never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_queued <= QUEUE_W'(OUTBOX_DEPTH))
        else $error("outbox count beyond depth");

    // the outbox and send counters hold without an event
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_sent) && $stable(r_queued) && $stable(r_trans))
        else $error("state changed without an event");

endmodule

`default_nettype wire

// File: tb/stop_and_wait_link_client_test.sv
`default_nettype none

module stop_and_wait_link_client_test;
    import swl_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_ROWS     = 23;

    // event codes the block does not decode
    localparam logic [2:0] OP_UNDEF5 = 3'd5;
    localparam logic [2:0] OP_UNDEF6 = 3'd6;
    localparam logic [2:0] OP_UNDEF7 = 3'd7;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        LS_CONNECT_SENT = 2'd0,
        LS_CONNECTED    = 2'd1,
        LS_DISCONNECTED = 2'd2
    } t_link_state;

    // one line of the directed script; typed rows carry their single action
    typedef struct {
        t_in_item   ev;
        bit         typed;
        logic [2:0] action;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swl_in_if  in_ch ();
    swl_out_if out_ch ();
    swl_cfg_if cfg_ch ();

    stop_and_wait_link_client dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // link state as the client should hold it
    t_link_state          lk_state;
    logic [31:0]          lk_conn;
    logic [31:0]          lk_sent;
    logic [31:0]          lk_recv;
    logic [31:0]          lk_acked;
    logic [31:0]          lk_xmit;
    logic [QUEUE_W-1:0]   lk_queued;
    logic [7:0]           lk_idle;
    logic [7:0]           lk_limit;

    t_out_item burst[$];         // actions of the event being predicted
    t_out_item actions_due[$];   // actions still owed by the block

    int  bad_count = 0;
    int  hold_req  = 0;
    int  hold_done = 0;
    int  quiet     = 0;
    bit  steady    = 1'b0;

    t_row script [NUM_ROWS];

    function automatic void reset_link();
        lk_state  = LS_CONNECT_SENT;
        lk_conn   = '0;
        lk_sent   = '0;
        lk_recv   = '0;
        lk_acked  = '0;
        lk_xmit   = '0;
        lk_queued = '0;
        lk_idle   = '0;
        lk_limit  = EPOCH_LIMIT_RESET;
    endfunction

    // a zero limit is dropped
    function automatic void apply_limit(input logic [7:0] value);
        if (value != 8'd0)
            lk_limit = value;
    endfunction

    function automatic logic [31:0] front_seq();
        return lk_sent - {{(32-QUEUE_W){1'b0}}, lk_queued} + 32'd1;
    endfunction

    function automatic void add_action(input logic [2:0] act, input logic [31:0] seq,
                                       input logic [31:0] conn, input logic was_open);
        t_out_item r;
        r.action   = act;
        r.seq_out  = seq;
        r.conn_out = conn;
        r.was_open = was_open;
        r.last     = 1'b0;
        burst.push_back(r);
    endfunction

    // send the outbox front once the previous message is acknowledged
    function automatic void try_send();
        logic [31:0] next_ack;
        next_ack = lk_acked + 32'd1;
        if (lk_state == LS_CONNECTED && next_ack > lk_xmit && lk_queued != '0) begin
            add_action(ACT_DATA, front_seq(), lk_conn, 1'b0);
            lk_xmit = front_seq();
        end
    endfunction

    // advance the link by one event and collect its actions in burst
    function automatic void run_link_event(input t_in_item ev);
        logic was_open;
        burst.delete();
        case (ev.operation)
            OP_WRITE: begin
                if (ev.msg_length == 16'd0 || lk_queued >= OUTBOX_DEPTH) begin
                    add_action(ACT_REJECT, '0, '0, 1'b0);
                end else begin
                    lk_sent   = lk_sent + 32'd1;
                    lk_queued = lk_queued + 1'b1;
                    try_send();
                end
            end
            OP_RECV: begin
                if (lk_state != LS_DISCONNECTED && ev.msg_conn_id == lk_conn) begin
                    lk_idle = '0;
                    if (ev.msg_length == 16'd0) begin
                        if (ev.msg_seq == lk_acked + 32'd1)
                            lk_acked = ev.msg_seq;
                        if (lk_queued != '0 && ev.msg_seq == front_seq())
                            lk_queued = lk_queued - 1'b1;
                    end else if (ev.msg_seq == lk_recv + 32'd1) begin
                        lk_recv = ev.msg_seq;
                        add_action(ACT_DELIVER, ev.msg_seq, lk_conn, 1'b0);
                        add_action(ACT_ACK, lk_recv, lk_conn, 1'b0);
                    end
                    try_send();
                end
            end
            OP_TICK: begin
                if (lk_state != LS_DISCONNECTED) begin
                    if (lk_state == LS_CONNECT_SENT) begin
                        add_action(ACT_CONNECT, '0, '0, 1'b0);
                    end else begin
                        add_action(ACT_ACK, lk_recv, lk_conn, 1'b0);
                        if (lk_queued != '0)
                            add_action(ACT_DATA, front_seq(), lk_conn, 1'b0);
                    end
                    if (lk_idle < EPOCH_CNT_MAX)
                        lk_idle = lk_idle + 8'd1;
                    if (lk_idle >= lk_limit) begin
                        lk_state = LS_DISCONNECTED;
                        add_action(ACT_TIMEOUT, '0, '0, 1'b0);
                    end
                end
            end
            OP_CONNECT: begin
                if (lk_state == LS_CONNECT_SENT && ev.connect_ok) begin
                    lk_conn  = ev.msg_conn_id;
                    lk_state = LS_CONNECTED;
                end
                try_send();
            end
            OP_CLOSE: begin
                was_open = (lk_state != LS_DISCONNECTED);
                lk_state = LS_DISCONNECTED;
                add_action(ACT_CLOSED, '0, '0, was_open);
            end
            default: ;
        endcase
        if (burst.size() == 0)
            add_action(ACT_NONE, '0, '0, 1'b0);
        burst[burst.size()-1].last = 1'b1;
    endfunction

    function automatic t_in_item make_event(input logic [2:0] op, input logic [31:0] conn,
                                            input logic [31:0] seq, input logic [15:0] len,
                                            input logic ok);
        t_in_item ev;
        ev.operation   = op;
        ev.msg_conn_id = conn;
        ev.msg_seq     = seq;
        ev.msg_length  = len;
        ev.connect_ok  = ok;
        return ev;
    endfunction

    function automatic t_row row(input logic [2:0] op, input logic [31:0] conn,
                                 input logic [31:0] seq, input logic [15:0] len,
                                 input logic ok, input bit typed = 1'b0,
                                 input logic [2:0] act = ACT_NONE);
        t_row r;
        r.ev     = make_event(op, conn, seq, len, ok);
        r.typed  = typed;
        r.action = act;
        return r;
    endfunction

    function automatic logic [15:0] payload_len();
        return ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
    endfunction

    // mostly well-formed traffic on a live link, with some noise mixed in
    function automatic t_in_item random_event();
        t_in_item ev;
        int       pick;
        ev   = make_event(OP_RECV, lk_conn, '0, '0, 1'($urandom_range(1)));
        pick = $urandom_range(99);
        if (pick < 30) begin
            ev = make_event(OP_WRITE, $urandom, $urandom, payload_len(), 1'($urandom_range(1)));
        end else if (pick < 55) begin
            ev.msg_seq = (lk_acked != lk_xmit) ? lk_xmit : lk_acked + 32'd1;
        end else if (pick < 75) begin
            ev.msg_seq    = lk_recv + 32'd1;
            ev.msg_length = 16'($urandom_range(65535, 1));
        end else if (pick < 83) begin
            // tick only while the link survives it; otherwise a stale ack
            if (int'(lk_idle) + 1 < int'(lk_limit))
                ev.operation = OP_TICK;
        end else if (pick < 88) begin
            ev.operation   = OP_CONNECT;
            ev.msg_conn_id = $urandom;
        end else begin
            ev.operation = 3'($urandom_range(7));
            if (ev.operation == OP_TICK || ev.operation == OP_CLOSE)
                ev.operation = OP_RECV;
            ev.msg_conn_id = $urandom_range(1) ? lk_conn : 32'($urandom);
            ev.msg_seq     = $urandom;
            ev.msg_length  = 16'($urandom);
        end
        return ev;
    endfunction

    // offer one event, wait for its transaction, then log what it owes
    task automatic offer(input t_in_item ev, input bit typed = 1'b0,
                         input logic [2:0] act = ACT_NONE);
        t_out_item want;
        while (!steady && $urandom_range(99) < 13) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= ev.operation;
        in_ch.msg_conn_id <= ev.msg_conn_id;
        in_ch.msg_seq     <= ev.msg_seq;
        in_ch.msg_length  <= ev.msg_length;
        in_ch.connect_ok  <= ev.connect_ok;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        run_link_event(ev);
        if (typed) begin
            want = '{action: act, seq_out: 32'd0, conn_out: 32'd0, was_open: 1'b0, last: 1'b1};
            actions_due.push_back(want);
        end else begin
            foreach (burst[k])
                actions_due.push_back(burst[k]);
        end
    endtask

    // hold the event channel low until every owed action has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (actions_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_epoch_limit(input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        apply_limit(value);
        cfg_ch.valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_WRITE;
        in_ch.msg_conn_id <= '0;
        in_ch.msg_seq     <= '0;
        in_ch.msg_length  <= '0;
        in_ch.connect_ok  <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        reset_link();

        script = '{
            row(OP_TICK,    '0,       '0,       16'd0,      1'b0, 1'b1, ACT_CONNECT),
            row(OP_WRITE,   '0,       '0,       16'd0,      1'b0, 1'b1, ACT_REJECT),
            row(OP_WRITE,   ALL_ONES, ALL_ONES, 16'hFFFF,   1'b1, 1'b1, ACT_NONE),
            row(OP_WRITE,   '0,       '0,       16'd1,      1'b0, 1'b1, ACT_NONE),
            row(OP_CONNECT, 32'h1234, '0,       16'd0,      1'b0, 1'b1, ACT_NONE),
            row(OP_RECV,    '0,       32'd5,    16'd0,      1'b0),
            row(OP_CONNECT, ALL_ONES, '0,       16'd0,      1'b1),
            row(OP_CONNECT, '0,       '0,       16'd0,      1'b1),
            row(OP_RECV,    '0,       32'd1,    16'd0,      1'b0, 1'b1, ACT_NONE),
            row(OP_RECV,    ALL_ONES, 32'd2,    16'd5,      1'b0),
            row(OP_RECV,    ALL_ONES, 32'd1,    16'hFFFF,   1'b0),
            row(OP_RECV,    ALL_ONES, 32'd1,    16'd0,      1'b0),
            row(OP_RECV,    ALL_ONES, ALL_ONES, 16'd0,      1'b1),
            row(OP_TICK,    '0,       '0,       16'd0,      1'b0),
            row(OP_UNDEF5,  ALL_ONES, ALL_ONES, 16'hFFFF,   1'b1, 1'b1, ACT_NONE),
            row(OP_UNDEF6,  ALL_ONES, ALL_ONES, 16'hFFFF,   1'b1, 1'b1, ACT_NONE),
            row(OP_UNDEF7,  ALL_ONES, ALL_ONES, 16'hFFFF,   1'b1, 1'b1, ACT_NONE),
            row(OP_RECV,    ALL_ONES, 32'd2,    16'd0,      1'b0),
            row(OP_TICK,    '0,       '0,       16'd0,      1'b0),
            row(OP_WRITE,   '0,       '0,       16'h8000,   1'b0),
            row(OP_RECV,    ALL_ONES, 32'd2,    16'd1,      1'b0),
            row(OP_RECV,    ALL_ONES, 32'd3,    16'd0,      1'b0),
            row(OP_RECV,    ALL_ONES, 32'd0,    16'd7,      1'b0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a zero limit must leave the reset value in place
        set_epoch_limit(8'd0);
        foreach (script[k])
            offer(script[k].ev, script[k].typed, script[k].action);
        drain();

        // widest limit; open with a long receiver hold-off to back up the input
        set_epoch_limit(8'd255);
        hold_req++;
        for (int n = 0; n < 170; n++) begin
            steady = (n >= 100 && n < 160);
            offer(random_event());
        end
        steady = 1'b0;
        drain();

        set_epoch_limit(8'd3);
        for (int n = 0; n < 120; n++)
            offer(random_event());
        drain();

        // narrowest limit: any tick now loses the link
        set_epoch_limit(8'd1);
        for (int n = 0; n < 100; n++)
            offer(random_event());

        // end the link by timeout or by close
        offer(make_event(OP_WRITE, $urandom, $urandom, 16'($urandom_range(65535, 1)), 1'b0));
        offer(make_event(OP_WRITE, $urandom, $urandom, 16'($urandom_range(65535, 1)), 1'b0));
        if ($urandom_range(1)) begin
            offer(make_event(OP_TICK, $urandom, $urandom, 16'($urandom), 1'($urandom_range(1))));
            offer(make_event(OP_CLOSE, $urandom, $urandom, 16'($urandom), 1'b1));
        end else begin
            offer(make_event(OP_CLOSE, $urandom, $urandom, 16'($urandom), 1'b0));
            offer(make_event(OP_CLOSE, $urandom, $urandom, 16'($urandom), 1'b1));
        end

        // dead link: writes pile up until rejected, closes still report, all else ignored
        for (int n = 0; n < 20; n++)
            offer(make_event(OP_WRITE, $urandom, $urandom, 16'($urandom_range(65535, 1)), 1'b0));
        for (int n = 0; n < 25; n++)
            offer(make_event(3'($urandom_range(7)), $urandom, $urandom, 16'($urandom),
                             1'($urandom_range(1))));

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_count == 0)
            $display("stop_and_wait_link_client_test: PASS");
        else
            $display("stop_and_wait_link_client_test: FAIL");
        $finish;
    end

    // action receiver: random stalls, plus the requested long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    // compare each action transaction with the oldest one owed
    always @(posedge i_clk) begin : check_actions
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{action: out_ch.action, seq_out: out_ch.seq_out, conn_out: out_ch.conn_out,
                    was_open: out_ch.was_open, last: out_ch.last};
            if (actions_due.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected action %0d seq %h conn %h open %b last %b",
                             got.action, got.seq_out, got.conn_out, got.was_open, got.last);
            end else begin
                want = actions_due.pop_front();
                if (got.action !== want.action || got.seq_out !== want.seq_out ||
                    got.conn_out !== want.conn_out || got.was_open !== want.was_open ||
                    got.last !== want.last) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("action mismatch: expected %0d/%h/%h/%b/%b got %0d/%h/%h/%b/%b",
                                 want.action, want.seq_out, want.conn_out, want.was_open,
                                 want.last, got.action, got.seq_out, got.conn_out,
                                 got.was_open, got.last);
                end
            end
        end
    end

    // end the run if no transaction moves on any channel for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("stop_and_wait_link_client_test: FAIL");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
